FILE: design/gcpd_pkg.sv
// Shared constants, tables and helpers for the point-pair distance core.
`default_nettype none

package gcpd_pkg;

    localparam int COORD_W      = 32;
    localparam int FRAC_W       = 16;
    localparam int OUT_W        = COORD_W + 1;
    localparam int ANGLE_W      = COORD_W + 2;
    localparam int MAG_W        = COORD_W + 1;
    localparam int UNIT_W       = 32;
    localparam int ROT_W        = 34;
    localparam int CORDIC_STEPS = 30;
    localparam int RAD_W        = 2 * MAG_W;
    localparam int ROOT_W       = MAG_W;
    localparam int PHASE_LSB    = FRAC_W + 1 + 32;
    localparam int SEP_SHIFT    = 60 - FRAC_W;

    localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic signed [ROT_W-1:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [ROT_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic [OUT_W-1:0] SPHERE_MAX =
        OUT_W'((64'd1073741824 * 64'(PI_Q30)) >> SEP_SHIFT);

    localparam logic [31:0] TURN_TABLE [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    function automatic logic [MAG_W-1:0] magnitude(input logic signed [ANGLE_W-1:0] v);
        logic [ANGLE_W-1:0] n;
        n = -v;
        return v[ANGLE_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/great_circle_or_planar_distance_core.sv
// Top level of the point-pair distance core: Euclidean distance or haversine angle.
`default_nettype none

// The core takes one request per clock and busy is always low. Each request
// leaves its result on separation with done high for one cycle, and results
// come out in request order. The latency is set by the sine and cosine unit
// (34 stages), the product terms (3), the 33-stage square root and the
// 30-stage arcsine CORDIC with its final scaling.
// The receiver cannot hold results off, so it must take one every cycle.
// coordinate_mode selects planar (0) or spherical (1) and is written through the
// cfg channel, which is always ready; change it only with no request in flight.

module great_circle_or_planar_distance_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [gcpd_pkg::COORD_W-1:0]  first_x,
    input  logic signed [gcpd_pkg::COORD_W-1:0]  first_y,
    input  logic signed [gcpd_pkg::COORD_W-1:0]  second_x,
    input  logic signed [gcpd_pkg::COORD_W-1:0]  second_y,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_data,
    output logic                                 done,
    output logic [gcpd_pkg::OUT_W-1:0]           separation
);
    import gcpd_pkg::*;

    localparam int CART_STAGE = 3;
    localparam int SC_STAGE   = 34;
    localparam int H_STAGE    = SC_STAGE + 3;
    localparam int SQ_STAGE   = H_STAGE + ROOT_W;
    localparam int PROD_STAGE = SQ_STAGE + CORDIC_STEPS + 1;
    localparam int OUT_STAGE  = PROD_STAGE + 1;
    localparam logic [30:0] H_ONE = 31'd1073741824;

    logic coordinate_mode_reg;
    logic vld_reg  [OUT_STAGE+1];
    logic mode_reg [OUT_STAGE+1];

    logic signed [COORD_W-1:0] x1_reg;
    logic signed [COORD_W-1:0] y1_reg;
    logic signed [COORD_W-1:0] x2_reg;
    logic signed [COORD_W-1:0] y2_reg;

    logic signed [ANGLE_W-1:0] dlat;
    logic signed [ANGLE_W-1:0] dlon;
    logic signed [ANGLE_W-1:0] lat1;
    logic signed [ANGLE_W-1:0] lat2;
    logic signed [UNIT_W-1:0]  s_lat;
    logic signed [UNIT_W-1:0]  s_lon;
    logic signed [UNIT_W-1:0]  cos1;
    logic signed [UNIT_W-1:0]  cos2;

    logic signed [63:0]       p_lat;
    logic signed [63:0]       p_lon;
    logic signed [63:0]       p_cc;
    logic signed [63:0]       p_t;
    logic signed [UNIT_W-1:0] sl2_reg;
    logic signed [UNIT_W-1:0] so2_reg;
    logic signed [UNIT_W-1:0] cc_reg;
    logic signed [UNIT_W-1:0] sl2d_reg;
    logic signed [UNIT_W-1:0] t_reg;
    logic signed [ROT_W-1:0]  hs;
    logic [30:0]              h_next;
    logic [30:0]              h_reg;
    logic [30:0]              hc;

    logic [MAG_W-1:0] cmx_reg;
    logic [MAG_W-1:0] cmy_reg;
    logic [RAD_W-1:0] sqx_reg;
    logic [RAD_W-1:0] sqy_reg;
    logic [RAD_W-1:0] cs_reg [CART_STAGE:H_STAGE];

    logic [RAD_W-1:0]  rad_a;
    logic [RAD_W-1:0]  rad_b;
    logic [ROOT_W-1:0] root_a;
    logic [ROOT_W-1:0] root_b;

    logic signed [ROT_W-1:0] ax_in  [CORDIC_STEPS];
    logic signed [ROT_W-1:0] ay_in  [CORDIC_STEPS];
    logic signed [ROT_W-1:0] az_in  [CORDIC_STEPS];
    logic signed [ROT_W-1:0] ax_reg [CORDIC_STEPS];
    logic signed [ROT_W-1:0] ay_reg [CORDIC_STEPS];
    logic signed [ROT_W-1:0] az_reg [CORDIC_STEPS];

    logic [OUT_W-1:0] cr_reg [SQ_STAGE+1:PROD_STAGE];
    logic [30:0]      zc;
    logic [62:0]      prod_reg;
    logic [OUT_W-1:0] sep_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coordinate_mode_reg <= 1'b0;
            for (int k = 0; k <= OUT_STAGE; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                coordinate_mode_reg <= cfg_data;
            end
            vld_reg[0] <= start && !busy;
            for (int k = 1; k <= OUT_STAGE; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg      <= first_x;
        y1_reg      <= first_y;
        x2_reg      <= second_x;
        y2_reg      <= second_y;
        mode_reg[0] <= coordinate_mode_reg;
        for (int k = 1; k <= OUT_STAGE; k++)
        begin
            mode_reg[k] <= mode_reg[k-1];
        end
    end

    // Differences carry one more fraction bit, so latitudes are doubled to match.
    assign dlat = ANGLE_W'(y2_reg) - ANGLE_W'(y1_reg);
    assign dlon = ANGLE_W'(x2_reg) - ANGLE_W'(x1_reg);
    assign lat1 = ANGLE_W'(y1_reg) <<< 1;
    assign lat2 = ANGLE_W'(y2_reg) <<< 1;

    gcpd_sincos u_sc_dlat
    (
        .clk    (clk),
        .angle  (dlat),
        .sine   (s_lat),
        .cosine ()
    );

    gcpd_sincos u_sc_dlon
    (
        .clk    (clk),
        .angle  (dlon),
        .sine   (s_lon),
        .cosine ()
    );

    gcpd_sincos u_sc_lat1
    (
        .clk    (clk),
        .angle  (lat1),
        .sine   (),
        .cosine (cos1)
    );

    gcpd_sincos u_sc_lat2
    (
        .clk    (clk),
        .angle  (lat2),
        .sine   (),
        .cosine (cos2)
    );

    assign p_lat = 64'(s_lat) * 64'(s_lat);
    assign p_lon = 64'(s_lon) * 64'(s_lon);
    assign p_cc  = 64'(cos1) * 64'(cos2);
    assign p_t   = 64'(so2_reg) * 64'(cc_reg);
    assign hs    = ROT_W'(sl2d_reg) + ROT_W'(t_reg);

    always_comb
    begin
        if (hs[ROT_W-1])
        begin
            h_next = '0;
        end
        else if (hs > ONE_Q30)
        begin
            h_next = H_ONE;
        end
        else
        begin
            h_next = hs[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        sl2_reg  <= UNIT_W'(p_lat >>> 30);
        so2_reg  <= UNIT_W'(p_lon >>> 30);
        cc_reg   <= UNIT_W'(p_cc >>> 30);
        sl2d_reg <= sl2_reg;
        t_reg    <= UNIT_W'(p_t >>> 30);
        h_reg    <= h_next;
    end

    always_ff @(posedge clk)
    begin
        cmx_reg            <= magnitude(ANGLE_W'(x1_reg) - ANGLE_W'(x2_reg));
        cmy_reg            <= magnitude(ANGLE_W'(y1_reg) - ANGLE_W'(y2_reg));
        sqx_reg            <= RAD_W'(cmx_reg) * RAD_W'(cmx_reg);
        sqy_reg            <= RAD_W'(cmy_reg) * RAD_W'(cmy_reg);
        cs_reg[CART_STAGE] <= sqx_reg + sqy_reg;
        for (int k = CART_STAGE + 1; k <= H_STAGE; k++)
        begin
            cs_reg[k] <= cs_reg[k-1];
        end
    end

    // The first root unit serves the planar sum of squares as well as sqrt(h).
    assign hc    = H_ONE - h_reg;
    assign rad_a = mode_reg[H_STAGE] ? RAD_W'({h_reg, 30'b0}) : cs_reg[H_STAGE];
    assign rad_b = RAD_W'({hc, 30'b0});

    gcpd_isqrt u_root_a
    (
        .clk      (clk),
        .radicand (rad_a),
        .root     (root_a)
    );

    gcpd_isqrt u_root_b
    (
        .clk      (clk),
        .radicand (rad_b),
        .root     (root_b)
    );

    always_comb
    begin
        ax_in[0] = signed'(ROT_W'(root_b));
        ay_in[0] = signed'(ROT_W'(root_a));
        az_in[0] = '0;
        for (int k = 1; k < CORDIC_STEPS; k++)
        begin
            ax_in[k] = ax_reg[k-1];
            ay_in[k] = ay_reg[k-1];
            az_in[k] = az_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (!ay_in[i][ROT_W-1] && (ay_in[i] != '0))
            begin
                ax_reg[i] <= ax_in[i] + (ay_in[i] >>> i);
                ay_reg[i] <= ay_in[i] - (ax_in[i] >>> i);
                az_reg[i] <= az_in[i] + signed'(ROT_W'(TURN_TABLE[i]));
            end
            else
            begin
                ax_reg[i] <= ax_in[i] - (ay_in[i] >>> i);
                ay_reg[i] <= ay_in[i] + (ax_in[i] >>> i);
                az_reg[i] <= az_in[i] - signed'(ROT_W'(TURN_TABLE[i]));
            end
        end
    end

    always_comb
    begin
        if (az_reg[CORDIC_STEPS-1][ROT_W-1])
        begin
            zc = '0;
        end
        else if (az_reg[CORDIC_STEPS-1] > ONE_Q30)
        begin
            zc = H_ONE;
        end
        else
        begin
            zc = az_reg[CORDIC_STEPS-1][30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        cr_reg[SQ_STAGE+1] <= root_a;
        for (int k = SQ_STAGE + 2; k <= PROD_STAGE; k++)
        begin
            cr_reg[k] <= cr_reg[k-1];
        end
        prod_reg <= 63'(zc) * 63'(PI_Q30);
        sep_reg  <= mode_reg[PROD_STAGE] ? OUT_W'(prod_reg >> SEP_SHIFT)
                                         : cr_reg[PROD_STAGE];
    end

    assign done       = vld_reg[OUT_STAGE];
    assign separation = sep_reg;

    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, OUT_STAGE + 1))
        else $error("result strobe without a matching request");

    a_sphere_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done && mode_reg[OUT_STAGE] |-> separation <= SPHERE_MAX)
        else $error("spherical angle above pi");

    a_unit_roots: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SQ_STAGE] && mode_reg[SQ_STAGE]
            |-> root_a <= ROOT_W'(H_ONE) && root_b <= ROOT_W'(H_ONE))
        else $error("haversine square roots exceed one");

    a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> coordinate_mode_reg == $past(cfg_data))
        else $error("coordinate mode write lost");

endmodule

`default_nettype wire

FILE: design/gcpd_isqrt.sv
// Pipelined floor square root, one result bit per stage.
`default_nettype none

module gcpd_isqrt
(
    input  logic                          clk,
    input  logic [gcpd_pkg::RAD_W-1:0]    radicand,
    output logic [gcpd_pkg::ROOT_W-1:0]   root
);
    import gcpd_pkg::*;

    localparam int WORK_W = RAD_W + 2;

    logic [WORK_W-1:0] rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [WORK_W-1:0] rem_in   [ROOT_W];
    logic [ROOT_W-1:0] root_in  [ROOT_W];
    logic [WORK_W-1:0] trial    [ROOT_W];

    always_comb
    begin
        rem_in[0]  = WORK_W'(radicand);
        root_in[0] = '0;
        for (int k = 1; k < ROOT_W; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            root_in[k] = root_reg[k-1];
        end
        for (int k = 0; k < ROOT_W; k++)
        begin
            trial[k] = (WORK_W'(root_in[k]) << (ROOT_W - k))
                     | (WORK_W'(1) << (2 * (ROOT_W - 1 - k)));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ROOT_W; k++)
        begin
            if (rem_in[k] >= trial[k])
            begin
                rem_reg[k]  <= rem_in[k] - trial[k];
                root_reg[k] <= root_in[k] | (ROOT_W'(1) << (ROOT_W - 1 - k));
            end
            else
            begin
                rem_reg[k]  <= rem_in[k];
                root_reg[k] <= root_in[k];
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

FILE: design/gcpd_sincos.sv
// Pipelined angle reduction and rotation CORDIC giving sine and cosine in Q2.30.
`default_nettype none

module gcpd_sincos
(
    input  logic                                 clk,
    input  logic signed [gcpd_pkg::ANGLE_W-1:0]  angle,
    output logic signed [gcpd_pkg::UNIT_W-1:0]   sine,
    output logic signed [gcpd_pkg::UNIT_W-1:0]   cosine
);
    import gcpd_pkg::*;

    localparam int PROD_W = MAG_W + 32;
    localparam int FULL_W = PROD_W + 32;

    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] plo_reg;
    logic [PROD_W-1:0] phi_reg;
    logic              neg1_reg;
    logic              neg2_reg;
    logic [FULL_W-1:0] full;
    logic [31:0]       ph2_reg;
    logic [31:0]       phn;
    logic              fold;

    logic signed [ROT_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [ROT_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [ROT_W-1:0] z_reg [CORDIC_STEPS+1];
    logic                    flip_reg [CORDIC_STEPS+1];

    logic signed [ROT_W-1:0]  xc;
    logic signed [ROT_W-1:0]  yc;
    logic signed [UNIT_W-1:0] sine_reg;
    logic signed [UNIT_W-1:0] cosine_reg;

    assign mag  = magnitude(angle);
    assign full = FULL_W'(plo_reg) + {phi_reg, 32'b0};
    assign phn  = neg2_reg ? (~ph2_reg) + 32'd1 : ph2_reg;
    assign fold = phn[31] ^ phn[30];

    // The phase is the fraction of a turn; half-turn folding keeps CORDIC in range.
    always_ff @(posedge clk)
    begin
        plo_reg     <= PROD_W'(mag) * PROD_W'(INV_TWO_PI_Q64[31:0]);
        phi_reg     <= PROD_W'(mag) * PROD_W'(INV_TWO_PI_Q64[63:32]);
        neg1_reg    <= angle[ANGLE_W-1];
        ph2_reg     <= full[PHASE_LSB+31:PHASE_LSB];
        neg2_reg    <= neg1_reg;
        x_reg[0]    <= CORDIC_GAIN_Q30;
        y_reg[0]    <= '0;
        z_reg[0]    <= ROT_W'(signed'({phn[31] ^ fold, phn[30:0]}));
        flip_reg[0] <= fold;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            flip_reg[i+1] <= flip_reg[i];
            if (!z_reg[i][ROT_W-1])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - signed'(ROT_W'(TURN_TABLE[i]));
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + signed'(ROT_W'(TURN_TABLE[i]));
            end
        end
        cosine_reg <= flip_reg[CORDIC_STEPS] ? UNIT_W'(-xc) : UNIT_W'(xc);
        sine_reg   <= flip_reg[CORDIC_STEPS] ? UNIT_W'(-yc) : UNIT_W'(yc);
    end

    always_comb
    begin
        xc = x_reg[CORDIC_STEPS];
        if (x_reg[CORDIC_STEPS] > ONE_Q30)
        begin
            xc = ONE_Q30;
        end
        else if (x_reg[CORDIC_STEPS] < -ONE_Q30)
        begin
            xc = -ONE_Q30;
        end
        yc = y_reg[CORDIC_STEPS];
        if (y_reg[CORDIC_STEPS] > ONE_Q30)
        begin
            yc = ONE_Q30;
        end
        else if (y_reg[CORDIC_STEPS] < -ONE_Q30)
        begin
            yc = -ONE_Q30;
        end
    end

    assign sine   = sine_reg;
    assign cosine = cosine_reg;

endmodule

`default_nettype wire

FILE: tb/tb_great_circle_or_planar_distance_core.sv
// Self-checking testbench for the point-pair distance core in both coordinate modes.

module tb_great_circle_or_planar_distance_core;

    import gcpd_pkg::*;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [OUT_W-1:0] sep_t;

    localparam logic MODE_PLANAR    = 1'b0;
    localparam logic MODE_SPHERICAL = 1'b1;
    localparam int   DRAIN_CYCLES   = 110;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    coord_t first_x;
    coord_t first_y;
    coord_t second_x;
    coord_t second_y;
    logic   cfg_valid;
    logic   cfg_ready;
    logic   cfg_data;
    logic   done;
    sep_t   separation;

    sep_t   expected_separation[$];
    logic   active_mode;
    int     sender_idle_pct;
    int     error_count;
    int     requests_sent;
    int     results_checked;
    int     spherical_requests;

    great_circle_or_planar_distance_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .first_x    (first_x),
        .first_y    (first_y),
        .second_x   (second_x),
        .second_y   (second_y),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .done       (done),
        .separation (separation)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [127:0] floor_root(input logic [127:0] v);
        logic [127:0] root;
        logic [127:0] cand;
        root = '0;
        for (int b = 40; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= v)
                root = cand;
        end
        return root;
    endfunction

    function automatic longint clamp_one(input longint v);
        if (v > longint'(ONE_Q30))
            return longint'(ONE_Q30);
        if (v < -longint'(ONE_Q30))
            return -longint'(ONE_Q30);
        return v;
    endfunction

    function automatic void rotate_angle(input longint ang, input int fb,
                                         output longint sn, output longint cs);
        logic [127:0] prod;
        logic [31:0]  phase;
        logic         flip;
        longint       z;
        longint       x;
        longint       y;
        longint       dx;
        longint       dy;
        longint       mag;
        mag = (ang < 0) ? -ang : ang;
        prod = 128'(mag) * 128'(INV_TWO_PI_Q64);
        phase = 32'(prod >> (fb + 32));
        if (ang < 0)
            phase = -phase;
        flip = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
        if (flip)
            phase = phase + 32'h8000_0000;
        z = longint'(signed'(phase));
        x = longint'(CORDIC_GAIN_Q30);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(TURN_TABLE[i]);
            end
            else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(TURN_TABLE[i]);
            end
        end
        x = clamp_one(x);
        y = clamp_one(y);
        if (flip) begin
            x = -x;
            y = -y;
        end
        sn = y;
        cs = x;
    endfunction

    function automatic sep_t predict_separation(input logic mode, input coord_t x1,
                                                input coord_t y1, input coord_t x2,
                                                input coord_t y2);
        longint       s_lat;
        longint       s_lon;
        longint       c1;
        longint       c2;
        longint       unused;
        longint       h;
        longint       x;
        longint       y;
        longint       z;
        longint       dx;
        longint       dy;
        logic [127:0] mx;
        logic [127:0] my;
        logic [127:0] d;
        if (mode == MODE_SPHERICAL) begin
            rotate_angle(longint'(y2) - longint'(y1), FRAC_W + 1, s_lat, unused);
            rotate_angle(longint'(x2) - longint'(x1), FRAC_W + 1, s_lon, unused);
            rotate_angle(longint'(y1), FRAC_W, unused, c1);
            rotate_angle(longint'(y2), FRAC_W, unused, c2);
            h = ((s_lat * s_lat) >>> 30)
                + ((((s_lon * s_lon) >>> 30) * ((c1 * c2) >>> 30)) >>> 30);
            if (h < 0)
                h = 0;
            if (h > longint'(ONE_Q30))
                h = longint'(ONE_Q30);
            y = longint'(floor_root(128'(h) << 30));
            x = longint'(floor_root(128'(longint'(ONE_Q30) - h) << 30));
            z = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(TURN_TABLE[i]);
                end
                else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(TURN_TABLE[i]);
                end
            end
            if (z < 0)
                z = 0;
            if (z > longint'(ONE_Q30))
                z = longint'(ONE_Q30);
            d = (128'(z) * 128'(PI_Q30)) >> SEP_SHIFT;
        end
        else begin
            dx = longint'(x1) - longint'(x2);
            dy = longint'(y1) - longint'(y2);
            mx = 128'((dx < 0) ? -dx : dx);
            my = 128'((dy < 0) ? -dy : dy);
            d = floor_root(mx * mx + my * my);
        end
        if (d > 128'({OUT_W{1'b1}}))
            d = 128'({OUT_W{1'b1}});
        return d[OUT_W-1:0];
    endfunction

    always @(posedge clk) begin
        if (rst_n && done) begin
            if (expected_separation.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, separation);
                error_count++;
            end
            else begin
                if (separation !== expected_separation[0]) begin
                    $display("%0t: separation mismatch, expected %0d, actual %0d",
                             $time, expected_separation[0], separation);
                    error_count++;
                end
                void'(expected_separation.pop_front());
                results_checked++;
            end
        end
    end

    task automatic send_request(input coord_t x1, input coord_t y1,
                                input coord_t x2, input coord_t y2);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        first_x  <= x1;
        first_y  <= y1;
        second_x <= x2;
        second_y <= y2;
        forever begin
            @(posedge clk);
            if (!busy)
                break;
        end
        expected_separation.push_back(predict_separation(active_mode, x1, y1, x2, y2));
        requests_sent++;
        if (active_mode == MODE_SPHERICAL)
            spherical_requests++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (expected_separation.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        forever begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        active_mode = mode;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic coord_t any_coord();
        case ($urandom_range(5))
            0: return coord_t'($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000);
            1: return coord_t'(int'($urandom_range(32'h6_0000)) - 32'h3_0000);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic coord_t earth_coord(input int span);
        return coord_t'(int'($urandom_range(2 * span)) - span);
    endfunction

    task automatic test_planar_directed();
        coord_t hi;
        coord_t lo;
        hi = coord_t'(32'h7FFF_FFFF);
        lo = coord_t'(32'h8000_0000);
        send_request(0, 0, 0, 0);
        send_request(hi, hi, hi, hi);
        send_request(lo, lo, hi, hi);
        send_request(hi, lo, lo, hi);
        send_request(lo, 0, hi, 0);
        send_request(0, hi, 0, lo);
        send_request(32'sh0003_0000, 0, 0, 32'sh0004_0000);
        send_request(-1, -1, 1, 1);
        send_request(lo, lo, lo, lo);
    endtask

    task automatic test_spherical_directed();
        coord_t hi;
        coord_t lo;
        hi = coord_t'(32'h7FFF_FFFF);
        lo = coord_t'(32'h8000_0000);
        send_request(0, 0, 0, 0);
        send_request(32'sh0001_2000, 32'sh0000_8000, 32'sh0001_2000, 32'sh0000_8000);
        send_request(0, 0, 32'sh0003_243F, 0);
        send_request(0, 32'sh0001_921F, 0, -32'sh0001_921F);
        send_request(hi, hi, lo, lo);
        send_request(lo, hi, hi, lo);
        send_request(hi, hi, hi, hi);
        send_request(32'sh0000_0001, 0, 0, 32'sh0000_0001);
        send_request(-32'sh0006_487F, 32'sh0000_4000, 32'sh0006_487F, -32'sh0000_4000);
        send_request(0, 0, 32'sh0000_0001, 32'sh0000_0001);
    endtask

    task automatic test_random_phase(input int idle_pct, input int count);
        logic   mode;
        coord_t lon;
        coord_t lat;
        sender_idle_pct = idle_pct;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                mode = logic'($urandom_range(1));
                if (mode != active_mode)
                    write_mode(mode);
            end
            if (active_mode == MODE_SPHERICAL && $urandom_range(3) != 0) begin
                lon = earth_coord(205887);
                lat = earth_coord(102944);
                send_request(lon, lat, earth_coord(205887), earth_coord(102944));
            end
            else if ($urandom_range(9) == 0) begin
                lon = any_coord();
                lat = any_coord();
                send_request(lon, lat, lon, lat);
            end
            else begin
                send_request(any_coord(), any_coord(), any_coord(), any_coord());
            end
        end
    endtask

    initial begin
        rst_n              = 1'b0;
        start              = 1'b0;
        first_x            = '0;
        first_y            = '0;
        second_x           = '0;
        second_y           = '0;
        cfg_valid          = 1'b0;
        cfg_data           = 1'b0;
        active_mode        = MODE_PLANAR;
        sender_idle_pct    = 0;
        error_count        = 0;
        requests_sent      = 0;
        results_checked    = 0;
        spherical_requests = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_planar_directed();
        write_mode(MODE_SPHERICAL);
        test_spherical_directed();
        write_mode(MODE_PLANAR);
        send_request(32'sh0001_0000, 0, 0, 0);
        test_random_phase(29, 300);
        test_random_phase(73, 300);
        test_random_phase(0, 300);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d requests (%0d spherical), checked %0d results.",
                 requests_sent, spherical_requests, results_checked);
        $display("Covered both modes, field extremes, coincident points and sender gaps.");
        if (error_count == 0 && expected_separation.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
